/* hdl/tgfo_pkg.sv */
// ----------------------------------------------------------------------------
// tgfo_pkg
// Shared widths, code constants and types for the glyph offset block.
// ----------------------------------------------------------------------------
package tgfo_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OFFSET_W    = 19;
  localparam int unsigned CODE_IDX_W  = 7;
  localparam int unsigned GLYPH_IDX_W = 14;
  localparam int unsigned GLYPH_SHIFT = 5;   // 32 bytes per glyph
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CODE_BASE   = 8'd161;
  localparam logic [BYTE_W-1:0] CODE_TOP    = 8'd254;
  localparam logic [BYTE_W-1:0] ASCII_ROW   = 8'd163;
  localparam logic [BYTE_W-1:0] ASCII_SHIFT = 8'd128;
  localparam logic [BYTE_W-1:0] SPACE_CODE  = 8'd161;
  localparam logic [BYTE_W-1:0] SPACE_BYTE  = 8'd32;
  localparam logic [BYTE_W-1:0] ASCII_FIRST = 8'd33;
  localparam logic [BYTE_W-1:0] ASCII_LAST  = 8'd127;

  localparam logic [GLYPH_IDX_W-1:0] ROW_LEN = 14'd94;

  typedef struct packed {
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] trail;
  } code_t;

  // one code pair moving between the stages
  typedef struct packed {
    logic  valid;
    code_t code;
  } code_req_t;

endpackage

/* hdl/tgfo_if.sv */
// ----------------------------------------------------------------------------
// tgfo_if
// Valid/ready channels for text bytes in and glyph offsets out.
// ----------------------------------------------------------------------------
interface tgfo_in_if;
  logic                       valid;
  logic                       ready;
  logic [tgfo_pkg::BYTE_W-1:0] text_byte;
  logic                       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tgfo_out_if;
  logic                         valid;
  logic                         ready;
  logic [tgfo_pkg::OFFSET_W-1:0] glyph_offset;
  logic                         bad_code;

  modport source (output valid, output glyph_offset, output bad_code, input ready);
  modport sink   (input valid, input glyph_offset, input bad_code, output ready);
endinterface

/* hdl/tgfo_front.sv */
// ----------------------------------------------------------------------------
// tgfo_front
// Accepts text bytes, holds a pending lead byte and forms code pairs.
// ----------------------------------------------------------------------------
module tgfo_front (
  input  logic                  clk,
  input  logic                  rst_n,
  tgfo_in_if.sink               in_ch,
  input  logic                  q_full,
  output tgfo_pkg::code_req_t   push
);

  logic                        lead_pending_r, lead_pending_nxt;
  logic [tgfo_pkg::BYTE_W-1:0] lead_byte_r, lead_byte_nxt;
  logic                        accept;
  logic                        is_ascii;
  logic                        is_space;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_ascii    = (in_ch.text_byte >= tgfo_pkg::ASCII_FIRST) &&
                       (in_ch.text_byte <= tgfo_pkg::ASCII_LAST);
  assign is_space    = (in_ch.text_byte == tgfo_pkg::SPACE_BYTE);

  always_comb begin
    lead_pending_nxt = lead_pending_r;
    lead_byte_nxt    = lead_byte_r;
    push.valid       = 1'b0;
    push.code.lead   = tgfo_pkg::SPACE_CODE;
    push.code.trail  = tgfo_pkg::SPACE_CODE;
    if (accept) begin
      priority if (lead_pending_r) begin
        // any byte completes the pair
        push.valid       = 1'b1;
        push.code.lead   = lead_byte_r;
        push.code.trail  = in_ch.text_byte;
        lead_pending_nxt = 1'b0;
        lead_byte_nxt    = '0;
      end else if (is_ascii) begin
        push.valid      = 1'b1;
        push.code.lead  = tgfo_pkg::ASCII_ROW;
        push.code.trail = in_ch.text_byte + tgfo_pkg::ASCII_SHIFT;
      end else if (is_space) begin
        push.valid = 1'b1;
      end else if (!in_ch.end_of_text) begin
        lead_pending_nxt = 1'b1;
        lead_byte_nxt    = in_ch.text_byte;
      end else begin
        // lead byte at end of text is dropped
        lead_pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      lead_byte_r    <= '0;
    end else begin
      lead_pending_r <= lead_pending_nxt;
      lead_byte_r    <= lead_byte_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pair_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && lead_pending_r) |=> !lead_pending_r)
    else $error("lead byte still pending after its trail byte");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> accept)
    else $error("code pair pushed without a transfer");

  a_lead_push_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !lead_pending_r && !push.valid && !in_ch.end_of_text) |=> lead_pending_r)
    else $error("lead byte not held");
`endif

endmodule

/* hdl/tgfo_queue.sv */
// ----------------------------------------------------------------------------
// tgfo_queue
// Short register queue of code pairs between the front and back stages.
// ----------------------------------------------------------------------------
module tgfo_queue #(
  parameter int unsigned DEPTH = tgfo_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tgfo_pkg::code_req_t push,
  output logic                full,
  output tgfo_pkg::code_req_t head,
  input  logic                pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tgfo_pkg::code_t    slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.code  = slot_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.code;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_lost: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !full)
    else $error("code pair pushed into a full queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

/* hdl/tgfo_back.sv */
// ----------------------------------------------------------------------------
// tgfo_back
// Checks a code pair and computes its glyph offset into an output register.
// ----------------------------------------------------------------------------
module tgfo_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tgfo_pkg::code_req_t head,
  output logic                pop,
  tgfo_out_if.source          out_ch
);

  logic                                  out_valid_r, out_valid_nxt;
  logic [tgfo_pkg::OFFSET_W-1:0]         offset_r;
  logic                                  bad_r;
  logic                                  lead_ok;
  logic                                  trail_ok;
  logic [tgfo_pkg::BYTE_W-1:0]           lead_rel;
  logic [tgfo_pkg::BYTE_W-1:0]           trail_rel;
  logic [tgfo_pkg::GLYPH_IDX_W-1:0]      glyph_idx;
  logic [tgfo_pkg::OFFSET_W-1:0]         offset_calc;

  assign lead_ok  = (head.code.lead >= tgfo_pkg::CODE_BASE) &&
                    (head.code.lead <= tgfo_pkg::CODE_TOP);
  assign trail_ok = (head.code.trail >= tgfo_pkg::CODE_BASE) &&
                    (head.code.trail <= tgfo_pkg::CODE_TOP);

  assign lead_rel  = head.code.lead - tgfo_pkg::CODE_BASE;
  assign trail_rel = head.code.trail - tgfo_pkg::CODE_BASE;

  // row * 94 + column, both in range only when the code is good
  assign glyph_idx =
    tgfo_pkg::GLYPH_IDX_W'(lead_rel[tgfo_pkg::CODE_IDX_W-1:0]) * tgfo_pkg::ROW_LEN +
    tgfo_pkg::GLYPH_IDX_W'(trail_rel[tgfo_pkg::CODE_IDX_W-1:0]);
  assign offset_calc = (lead_ok && trail_ok) ?
    {glyph_idx, {tgfo_pkg::GLYPH_SHIFT{1'b0}}} : '0;

  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      offset_r <= offset_calc;
      bad_r    <= !(lead_ok && trail_ok);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.glyph_offset = offset_r;
  assign out_ch.bad_code     = bad_r;

`ifndef NO_ASSERTIONS
  a_bad_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> offset_r == '0)
    else $error("bad code carries a nonzero offset");

  a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> offset_r[tgfo_pkg::GLYPH_SHIFT-1:0] == '0)
    else $error("glyph offset not glyph aligned");

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped pair not shown at the output");
`endif

endmodule

/* hdl/text_to_glyph_font_offset.sv */
// Throughput: one text byte per cycle while the queue is not full. A completed pair is
//   registered in the code-pair queue, then in the output register. The front and offset
//   stages each move one pair per cycle, decoupled by a small code-pair queue, while the
//   output is taken. The offset stage does one constant multiply by 94 and an add per cycle.
// Reset (synchronous, rst_n low) clears the pending lead byte, the queue and the
//   output valid flag; there is no clearing pass.
// ----------------------------------------------------------------------------
// text_to_glyph_font_offset
// Maps ASCII and two-byte codes of a text stream to 16x16 glyph font offsets.
// ----------------------------------------------------------------------------
module text_to_glyph_font_offset #(
  parameter int unsigned QUEUE_DEPTH = tgfo_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  tgfo_in_if.sink     in_ch,
  tgfo_out_if.source  out_ch
);

  tgfo_pkg::code_req_t push;
  tgfo_pkg::code_req_t head;
  logic                q_full;
  logic                pop;

  tgfo_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  tgfo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  tgfo_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
